@@ src/btau_pkg.sv @@
`default_nettype none

package btau_pkg;

    // Field widths of a request and a result
    localparam int ACT_W  = 4;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 6;
    localparam int BYTE_W = 8;

    // Table geometry
    localparam int ROWS_DEFAULT = 16;
    localparam int ROW_BYTES    = 64;

    // Shifts per iterative multiply or divide
    localparam int ITER_STEPS = 8;
    localparam int CNT_W      = 3;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_ADD   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SUB   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_MUL   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_DIV   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_MOD   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_AND   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_OR    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_XOR   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_STORE = 4'd8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ITER,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ src/btau_ram.sv @@
`default_nettype none

module btau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/byte_table_alu_update.sv @@
`default_nettype none

// Read-modify-write byte ALU over a table of ROWS rows of 64 byte cells. A request
// (start high while busy is low) names a cell by row and column and applies one of
// add/sub (saturating), mul (saturating quirk), div, mod, and, or, xor or store with
// the operand byte; the old and new cell values and a divide-by-zero flag come back
// on the result ports for one cycle, marked by o_strobe. The receiver cannot stall:
// take the result in the cycle it is strobed. Mul, and div/mod with a nonzero
// operand, go through one shared 9-bit add/subtract unit for eight shift steps
// between the table read and the write-back, with busy high throughout; every other
// action goes straight from table read to write-back with busy high. The result is
// strobed in the same cycle that busy falls, so it never blocks the next request. A
// row at or beyond ROWS is answered with all-zero fields in the next cycle and busy
// stays low. After reset the table is cleared one cell per cycle with busy held high.
module byte_table_alu_update_core
#(
    parameter int ROWS = btau_pkg::ROWS_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic [btau_pkg::ACT_W-1:0]   i_action,
    input  wire logic [btau_pkg::ROW_W-1:0]   i_row,
    input  wire logic [btau_pkg::COL_W-1:0]   i_column,
    input  wire logic [btau_pkg::BYTE_W-1:0]  i_operand,
    output logic                              busy,
    output logic                              o_strobe,
    output logic      [btau_pkg::BYTE_W-1:0]  o_new_value,
    output logic      [btau_pkg::BYTE_W-1:0]  o_old_value,
    output logic                              o_divide_by_zero
);

    import btau_pkg::*;

    localparam int DEPTH  = ROWS * ROW_BYTES;
    localparam int AW     = $clog2(DEPTH);
    localparam int FULL_W = ROW_W + COL_W;

    // Control state
    t_state            r_state,   n_state;
    logic [AW-1:0]     r_clr,     n_clr;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic              r_strobe,  n_strobe;

    // Request and working payload
    logic [ACT_W-1:0]  r_action,  n_action;
    logic [BYTE_W-1:0] r_opnd,    n_opnd;
    logic [AW-1:0]     r_addr,    n_addr;
    logic [BYTE_W-1:0] r_old,     n_old;
    logic [2*BYTE_W-1:0] r_acc,   n_acc;   // {hi, lo}: product, or {remainder, quotient}

    // Result registers
    logic [BYTE_W-1:0] r_new_value, n_new_value;
    logic [BYTE_W-1:0] r_old_value, n_old_value;
    logic              r_dz,        n_dz;

    // Table port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Shared add/subtract unit
    logic              unit_sub;
    logic [BYTE_W:0]   unit_a;
    logic [BYTE_W-1:0] unit_b;
    logic [BYTE_W+1:0] unit_sum;   // bit 9 set means a - b went negative

    logic [FULL_W-1:0] req_full;
    logic [AW-1:0]     req_addr;
    logic              req_oob;
    logic              accept;
    logic              iter_op;
    logic [BYTE_W-1:0] n_result;
    logic              result_dz;

    assign req_full = {i_row, i_column};
    assign req_addr = AW'(req_full);
    assign req_oob  = (9'(i_row) >= 9'(ROWS));
    assign accept   = start && (r_state == ST_IDLE);

    // Mul always iterates; div and mod only when the divisor is nonzero
    assign iter_op = (r_action == ACT_MUL)
                  || (((r_action == ACT_DIV) || (r_action == ACT_MOD)) && (r_opnd != '0));

    assign unit_sum = {1'b0, unit_a} + ({2'b00, unit_b} ^ {(BYTE_W+2){unit_sub}})
                    + {{(BYTE_W+1){1'b0}}, unit_sub};

    btau_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared unit operand selection
    always_comb begin
        unit_sub = 1'b0;
        unit_a   = {1'b0, r_old};
        unit_b   = r_opnd;
        if (r_state == ST_ITER) begin
            if (r_action == ACT_MUL) begin
                // shift-add multiply step
                unit_a = {1'b0, r_acc[2*BYTE_W-1:BYTE_W]};
                unit_b = r_acc[0] ? r_opnd : '0;
            end else begin
                // restoring divide step: trial subtract of the shifted remainder
                unit_sub = 1'b1;
                unit_a   = r_acc[2*BYTE_W-1:BYTE_W-1];
            end
        end else begin
            unit_sub = (r_action == ACT_SUB);
        end
    end

    // Final value from the action
    always_comb begin
        n_result  = r_old;
        result_dz = 1'b0;
        unique case (r_action)
            ACT_ADD:   n_result = unit_sum[BYTE_W] ? BYTE_MAX : unit_sum[BYTE_W-1:0];
            ACT_SUB:   n_result = unit_sum[BYTE_W+1] ? '0 : unit_sum[BYTE_W-1:0];
            ACT_MUL: begin
                // saturates only when the product, read as signed 16-bit, is >= 256
                if (!r_acc[2*BYTE_W-1] && (r_acc[2*BYTE_W-2:BYTE_W] != '0)) begin
                    n_result = BYTE_MAX;
                end else begin
                    n_result = r_acc[BYTE_W-1:0];
                end
            end
            ACT_DIV: begin
                if (r_opnd == '0) begin
                    n_result  = BYTE_MAX;
                    result_dz = 1'b1;
                end else begin
                    n_result = r_acc[BYTE_W-1:0];
                end
            end
            ACT_MOD: begin
                if (r_opnd == '0) begin
                    n_result  = r_old;
                    result_dz = 1'b1;
                end else begin
                    n_result = r_acc[2*BYTE_W-1:BYTE_W];
                end
            end
            ACT_AND:   n_result = r_old & r_opnd;
            ACT_OR:    n_result = r_old | r_opnd;
            ACT_XOR:   n_result = r_old ^ r_opnd;
            ACT_STORE: n_result = r_opnd;
            default:   n_result = r_old;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cnt       = r_cnt;
        n_strobe    = 1'b0;
        n_action    = r_action;
        n_opnd      = r_opnd;
        n_addr      = r_addr;
        n_old       = r_old;
        n_acc       = r_acc;
        n_new_value = r_new_value;
        n_old_value = r_old_value;
        n_dz        = r_dz;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = n_result;
        ram_raddr   = req_addr;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_opnd   = i_operand;
                    n_addr   = req_addr;
                    if (req_oob) begin
                        // row outside the table: answer zeros, touch nothing
                        n_strobe    = 1'b1;
                        n_new_value = '0;
                        n_old_value = '0;
                        n_dz        = 1'b0;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_old = ram_rdata;
                n_acc = {{BYTE_W{1'b0}}, ram_rdata};
                n_cnt = '0;
                n_state = iter_op ? ST_ITER : ST_FINISH;
            end
            ST_ITER: begin
                if (r_action == ACT_MUL) begin
                    n_acc = {unit_sum[BYTE_W:0], r_acc[BYTE_W-1:1]};
                end else if (!unit_sum[BYTE_W+1]) begin
                    n_acc = {unit_sum[BYTE_W-1:0], r_acc[BYTE_W-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[2*BYTE_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ITER_STEPS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                ram_we      = 1'b1;
                n_strobe    = 1'b1;
                n_new_value = n_result;
                n_old_value = r_old;
                n_dz        = result_dz;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_opnd      <= n_opnd;
        r_addr      <= n_addr;
        r_old       <= n_old;
        r_acc       <= n_acc;
        r_new_value <= n_new_value;
        r_old_value <= n_old_value;
        r_dz        <= n_dz;
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_strobe         = r_strobe;
    assign o_new_value      = r_new_value;
    assign o_old_value      = r_old_value;
    assign o_divide_by_zero = r_dz;

endmodule

`default_nettype wire
